### sv/rlu_pkg.sv
// Shared types and constants for the radix literal to u64 converter.
package rlu_pkg;

  localparam logic [1:0] FUNC_BIN = 2'd0;
  localparam logic [1:0] FUNC_DEC = 2'd1;
  localparam logic [1:0] FUNC_HEX = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;

  localparam logic [6:0] BIN_DIGITS = 7'd64;
  localparam logic [6:0] HEX_DIGITS = 7'd16;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_BACKTICK   = 8'h60;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_ONE        = 8'h31;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_LC_A       = 8'h61;
  localparam logic [7:0] CH_LC_F       = 8'h66;
  localparam logic [7:0] CH_UC_A       = 8'h41;
  localparam logic [7:0] CH_UC_F       = 8'h46;

  // largest value that can still be multiplied by ten without wrapping
  localparam logic [63:0] DEC_LIMIT = 64'h1999_9999_9999_9999;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [63:0] acc;
    logic [6:0]  count;
    logic        seen;
    logic [1:0]  err;
  } state_t;

endpackage

### sv/radix_literal_to_u64.sv
// Top level: numeric literal characters in, unsigned 64-bit value and status out.
// The last character is held in the input register, then its result in the output register.
// Throughput: one character per cycle unless stalled; the accumulator step is combinational.
// A result waiting at the output stalls only a following last character.
// Reset (synchronous, rst_n low) empties both stages and clears the accumulator state.
module radix_literal_to_u64 (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rlu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rlu_pkg::out_t out_data
);
  import rlu_pkg::*;

  logic   item_valid;
  in_t    item_data;
  logic   adv;
  state_t st_r;
  state_t st_nxt;
  state_t st_upd;
  out_t   step_res;
  logic   out_valid_r;
  logic   out_valid_nxt;
  out_t   out_data_r;

  // a character moves through unless it must emit and the output is still full
  assign adv = item_valid && (!item_data.last_char || !out_valid_r || out_ready);

  rlu_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (adv),
    .item_valid (item_valid),
    .item_data  (item_data)
  );

  rlu_step u_step (
    .cur  (st_r),
    .item (item_data),
    .upd  (st_upd),
    .res  (step_res)
  );

  always_comb begin
    st_nxt = st_r;
    if (adv) begin
      st_nxt = item_data.last_char ? '0 : st_upd;
    end
    out_valid_nxt = out_valid_r;
    if (adv && item_data.last_char) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item_data.last_char) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/rlu_in_reg.sv
// Input register stage: captures one character transaction per cycle unless stalled.
module rlu_in_reg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  rlu_pkg::in_t in_data,
  input  logic         take,
  output logic         item_valid,
  output rlu_pkg::in_t item_data
);
  import rlu_pkg::*;

  logic valid_r;
  logic valid_nxt;
  in_t  data_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

### sv/rlu_step.sv
// Per-character next-state logic and result formation.
module rlu_step (
  input  rlu_pkg::state_t cur,
  input  rlu_pkg::in_t    item,
  output rlu_pkg::state_t upd,
  output rlu_pkg::out_t   res
);
  import rlu_pkg::*;

  logic [7:0]  c;
  logic        is_dec;
  logic [3:0]  dv;
  logic [64:0] dec_sum;

  assign c      = item.char_code;
  assign is_dec = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dv     = c[3:0];
  // acc*10 + digit; only used when acc <= DEC_LIMIT, so the shifts lose nothing
  assign dec_sum = {1'b0, cur.acc[60:0], 3'b000} + {1'b0, cur.acc[62:0], 1'b0}
                 + {61'd0, dv};

  always_comb begin
    upd = cur;
    if (cur.err == ST_OK && c != CH_UNDERSCORE && c != CH_BACKTICK) begin
      unique case (item.func)
        FUNC_BIN: begin
          if (cur.count >= BIN_DIGITS) begin
            upd.err = ST_OVERFLOW;
          end else begin
            upd.count = cur.count + 7'd1;
            if (c != CH_ZERO && c != CH_ONE) begin
              upd.err = ST_BAD;
            end else begin
              upd.acc = {cur.acc[62:0], c[0]};
            end
          end
        end
        FUNC_DEC: begin
          if (!is_dec) begin
            upd.err = ST_BAD;
          end else if (c != CH_ZERO || cur.seen) begin
            upd.seen = 1'b1;
            if (cur.acc > DEC_LIMIT || dec_sum[64]) begin
              upd.err = ST_OVERFLOW;
            end else begin
              upd.acc = dec_sum[63:0];
            end
          end
        end
        FUNC_HEX: begin
          if (cur.count >= HEX_DIGITS) begin
            upd.err = ST_OVERFLOW;
          end else begin
            upd.count = cur.count + 7'd1;
            if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
              upd.acc = {cur.acc[59:0], c[3:0] + 4'd9};
            end else if (is_dec) begin
              upd.acc = {cur.acc[59:0], dv};
            end
          end
        end
        default: begin
          upd.err = ST_BAD;
        end
      endcase
    end
  end

  assign res.value  = (upd.err == ST_OK) ? upd.acc : 64'd0;
  assign res.status = upd.err;

endmodule

### sv/rlu_checker.sv
// Port-level assertions for the radix literal converter, bound to the top level.
module rlu_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input rlu_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input rlu_pkg::out_t out_data
);
  import rlu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_OVERFLOW ||
                   out_data.status == ST_BAD))
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.value == 64'd0)
    else $error("nonzero value with error status");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // with the result register empty nothing can hold back the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

endmodule

bind radix_literal_to_u64 rlu_checker u_rlu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### test/literal_value_checker.sv
`timescale 1ns / 1ps
// Checker: predicts the value and status of each literal and compares the results.
module literal_value_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  rlu_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  rlu_pkg::out_t out_data,
  output int            mismatch_count,
  output int            literals_outstanding
);
  import rlu_pkg::*;

  logic [63:0] acc;
  logic [6:0]  ndigits;
  logic        seen_nz;
  logic [1:0]  err;
  out_t        literal_results_q[$];
  int          n_mismatch = 0;
  int          n_pending = 0;

  assign mismatch_count = n_mismatch;
  assign literals_outstanding = n_pending;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    n_mismatch++;
  endtask

  task automatic clear_literal();
    acc = '0;
    ndigits = '0;
    seen_nz = 1'b0;
    err = ST_OK;
  endtask

  // one character step of the converter; queues a result on the last character
  task automatic fold_literal_char(input in_t t);
    logic [7:0]  c;
    logic [7:0]  nib;
    logic [63:0] d;
    out_t        r;
    c = t.char_code;
    if (err == ST_OK && c != CH_UNDERSCORE && c != CH_BACKTICK) begin
      case (t.func)
        FUNC_BIN: begin
          if (ndigits >= BIN_DIGITS) begin
            err = ST_OVERFLOW;
          end else begin
            ndigits++;
            if (c != CH_ZERO && c != CH_ONE) err = ST_BAD;
            else acc = {acc[62:0], c[0]};
          end
        end
        FUNC_DEC: begin
          if (c < CH_ZERO || c > CH_NINE) begin
            err = ST_BAD;
          end else if (c != CH_ZERO || seen_nz) begin
            seen_nz = 1'b1;
            nib = c - CH_ZERO;
            d = {56'd0, nib};
            // ~d is the headroom left for the add after the multiply
            if (acc > DEC_LIMIT) err = ST_OVERFLOW;
            else if (acc * 64'd10 > ~d) err = ST_OVERFLOW;
            else acc = acc * 64'd10 + d;
          end
        end
        FUNC_HEX: begin
          if (ndigits >= HEX_DIGITS) begin
            err = ST_OVERFLOW;
          end else begin
            ndigits++;
            if (c >= CH_LC_A && c <= CH_LC_F) begin
              nib = c - CH_LC_A + 8'd10;
              acc = {acc[59:0], nib[3:0]};
            end else if (c >= CH_UC_A && c <= CH_UC_F) begin
              nib = c - CH_UC_A + 8'd10;
              acc = {acc[59:0], nib[3:0]};
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
              nib = c - CH_ZERO;
              acc = {acc[59:0], nib[3:0]};
            end
          end
        end
        default: begin
          err = ST_BAD;
        end
      endcase
    end
    if (t.last_char) begin
      r.value = (err == ST_OK) ? acc : 64'd0;
      r.status = err;
      literal_results_q.insert(literal_results_q.size(), r);
      n_pending++;
      clear_literal();
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      clear_literal();
      literal_results_q.delete();
      n_pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (literal_results_q.size() == 0) begin
          report_mismatch("unexpected result, value", out_data.value, 64'd0);
        end else begin
          want = literal_results_q.pop_front();
          n_pending--;
          if (out_data.value !== want.value)
            report_mismatch("value", out_data.value, want.value);
          if (out_data.status !== want.status)
            report_mismatch("status", {62'd0, out_data.status}, {62'd0, want.status});
        end
      end
      if (in_valid && in_ready) fold_literal_char(in_data);
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench top: drives literal characters, stalls the result side, gives the verdict.
module tb;
  import rlu_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1024;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int   mismatch_count;
  int   literals_outstanding;
  int   items_sent = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   cycles = 0;
  in_t  lit_q[$];

  radix_literal_to_u64 dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  literal_value_checker u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data            (out_data),
    .mismatch_count      (mismatch_count),
    .literals_outstanding(literals_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic set_phase();
    if (items_sent < ITEM_TARGET / 3) begin
      send_idle = 28;
      recv_idle <= 79;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      send_idle = 79;
      recv_idle <= 28;
    end else begin
      send_idle = 0;
      recv_idle <= 0;
    end
  endtask

  task automatic put_char(input in_t ch);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data <= ch;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic add_raw(input logic [1:0] f, input logic [7:0] c);
    in_t t;
    t.func = f;
    t.char_code = c;
    t.last_char = 1'b0;
    lit_q.insert(lit_q.size(), t);
  endtask

  // occasionally slips a separator in front of the character
  task automatic add_char(input logic [1:0] f, input logic [7:0] c);
    if ($urandom_range(0, 11) == 0)
      add_raw(f, $urandom_range(0, 1) ? CH_UNDERSCORE : CH_BACKTICK);
    add_raw(f, c);
  endtask

  task automatic add_text(input logic [1:0] f, input string s);
    for (int i = 0; i < s.len(); i++) add_raw(f, s[i]);
  endtask

  task automatic send_literal();
    lit_q[lit_q.size() - 1].last_char = 1'b1;
    set_phase();
    foreach (lit_q[i]) put_char(lit_q[i]);
    items_sent += lit_q.size();
    lit_q.delete();
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned k;
    k = $urandom_range(0, 20);
    if (k < 10) return CH_ZERO + 8'(k);
    if (k < 16) return CH_LC_A + 8'(k - 10);
    if (k < 20) return CH_UC_A + 8'($urandom_range(0, 5));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_decimal(input logic [63:0] v);
    logic [7:0]  digs[$];
    logic [63:0] r;
    do begin
      r = v % 64'd10;
      digs.push_front(CH_ZERO + r[7:0]);
      v = v / 64'd10;
    end while (v != 64'd0);
    foreach (digs[i]) add_char(FUNC_DEC, digs[i]);
  endtask

  task automatic build_random_literal();
    int unsigned kind;
    int unsigned len;
    int unsigned sel;
    logic [63:0] v;
    kind = $urandom_range(0, 99);
    sel = $urandom_range(0, 9);
    if (kind < 25) begin
      len = (sel == 0) ? 64 : (sel == 1) ? $urandom_range(65, 70) : $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 39) == 0) add_char(FUNC_BIN, 8'($urandom_range(0, 255)));
        else add_char(FUNC_BIN, $urandom_range(0, 1) ? CH_ONE : CH_ZERO);
      end
    end else if (kind < 50) begin
      len = (sel == 0) ? 16 : (sel == 1) ? $urandom_range(17, 18) : $urandom_range(1, 15);
      for (int i = 0; i < len; i++) add_char(FUNC_HEX, hex_char());
    end else if (kind < 80) begin
      repeat ($urandom_range(0, 3)) add_char(FUNC_DEC, CH_ZERO);
      if (sel < 4) begin
        add_decimal({$urandom, $urandom});
      end else if (sel < 7) begin
        add_decimal(64'($urandom_range(0, 999)));
      end else if (sel < 9) begin
        // just below, at and just above the largest 64-bit value
        add_decimal(64'd1844674407370955161);
        add_char(FUNC_DEC, CH_ZERO + 8'($urandom_range(0, 9)));
      end else begin
        add_char(FUNC_DEC, CH_ZERO + 8'($urandom_range(1, 9)));
        repeat ($urandom_range(20, 23)) add_char(FUNC_DEC, CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 29) == 0) add_char(FUNC_DEC, 8'($urandom_range(0, 255)));
    end else begin
      // noise: any base code, any character, base may change mid-literal
      repeat ($urandom_range(1, 6)) add_raw(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    add_text(FUNC_BIN, "1_0`1");
    send_literal();
    add_text(FUNC_DEC, "007");
    send_literal();
    add_text(FUNC_DEC, "0");
    send_literal();
    add_text(FUNC_HEX, "`_");
    send_literal();
    add_text(FUNC_HEX, "aF9");
    send_literal();
    add_text(FUNC_HEX, "g1");
    send_literal();
    add_text(FUNC_BIN, "21");
    send_literal();
    add_text(FUNC_DEC, "1x");
    send_literal();
    add_text(FUNC_BIN, "1");
    add_text(FUNC_HEX, "f");
    send_literal();
    add_raw(FUNC_HEX, 8'h00);
    add_raw(FUNC_UNUSED, 8'hFF);
    send_literal();

    while (items_sent < ITEM_TARGET) begin
      build_random_literal();
      send_literal();
    end
    in_valid <= 1'b0;

    while (literals_outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && literals_outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
